// File: rtl/core/cpbdr_pkg.sv
package cpbdr_pkg;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_BLEND   = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;
    localparam logic [1:0] OP_PRESENT = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LINE_BYTES    = 3'd2;
    localparam logic [2:0] REG_BYTES_PER_PIX = 3'd3;
    localparam logic [2:0] REG_CLIP_LEFT     = 3'd4;
    localparam logic [2:0] REG_CLIP_TOP      = 3'd5;
    localparam logic [2:0] REG_CLIP_RIGHT    = 3'd6;
    localparam logic [2:0] REG_CLIP_BOTTOM   = 3'd7;

    // largest screen dimension, also the "no clip" edge after reset
    localparam int          MAX_DIM     = 4096;
    localparam int          DIM_W       = 13;
    localparam logic [12:0] DIM_NO_CLIP = 13'(MAX_DIM);

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // rectangle handed to the dirty box tracker
    typedef struct packed {
        logic               merge;
        logic               present;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } dirty_req_t;

    // dirty box as reported on present, valid in the lowest bit
    typedef struct packed {
        logic [DIM_W-1:0] bottom;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] left;
        logic             valid;
    } dirty_rpt_t;

endpackage

// File: rtl/core/cpbdr_blend.sv
module cpbdr_blend
    import cpbdr_pkg::*;
(
    input  logic [23:0] color,
    input  logic [23:0] old_pixel,
    input  logic [7:0]  alpha,
    output logic [23:0] mixed
);

    logic [7:0] inv_alpha;

    assign inv_alpha = ALPHA_OPAQUE - alpha;

    // per channel (c*a + o*(255-a)) / 255, divide done as (v + (v >> 8) + 1) >> 8
    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [15:0] prod_c;
        logic [15:0] prod_o;
        logic [16:0] sum;
        logic [16:0] adj;

        always_comb
        begin
            prod_c = color[ch*8 +: 8] * alpha;
            prod_o = old_pixel[ch*8 +: 8] * inv_alpha;
            sum    = {1'b0, prod_c} + {1'b0, prod_o};
            adj    = sum + {9'd0, sum[15:8]} + 17'd1;
        end

        assign mixed[ch*8 +: 8] = (alpha == ALPHA_OPAQUE) ? color[ch*8 +: 8] : adj[15:8];
    end

endmodule

// File: rtl/core/cpbdr_dirty.sv
module cpbdr_dirty
    import cpbdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dirty_req_t       req,
    input  logic [DIM_W-1:0] screen_width,
    input  logic [DIM_W-1:0] screen_height,
    output dirty_rpt_t       rpt
);

    logic             flag_reg, flag_next;
    logic [DIM_W-1:0] left_reg, left_next;
    logic [DIM_W-1:0] top_reg, top_next;
    logic [DIM_W-1:0] right_reg, right_next;
    logic [DIM_W-1:0] bottom_reg, bottom_next;

    logic signed [16:0] x_end, y_end, sw_s, sh_s, r_clamp, b_clamp;
    logic signed [16:0] x0_s, y0_s;
    logic        [15:0] x0, y0;
    logic               has_area;
    logic [DIM_W-1:0]   nl, nt, nr, nb;

    always_comb
    begin
        // clamp the rectangle to the screen
        x0     = req.x[15] ? 16'd0 : req.x;
        y0     = req.y[15] ? 16'd0 : req.y;
        x0_s   = $signed({1'b0, x0});
        y0_s   = $signed({1'b0, y0});
        x_end  = 17'(req.x) + 17'(req.w);
        y_end  = 17'(req.y) + 17'(req.h);
        sw_s   = $signed({4'd0, screen_width});
        sh_s   = $signed({4'd0, screen_height});
        r_clamp = (x_end > sw_s) ? sw_s : x_end;
        b_clamp = (y_end > sh_s) ? sh_s : y_end;
        has_area = (r_clamp > x0_s) && (b_clamp > y0_s);
        nl = x0[DIM_W-1:0];
        nt = y0[DIM_W-1:0];
        nr = r_clamp[DIM_W-1:0];
        nb = b_clamp[DIM_W-1:0];
    end

    always_comb
    begin
        flag_next   = flag_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        if (fire && req.present)
        begin
            flag_next = 1'b0;
        end
        else if (fire && req.merge && has_area)
        begin
            flag_next = 1'b1;
            if (!flag_reg)
            begin
                left_next   = nl;
                top_next    = nt;
                right_next  = nr;
                bottom_next = nb;
            end
            else
            begin
                if (nl < left_reg)   left_next   = nl;
                if (nt < top_reg)    top_next    = nt;
                if (nr > right_reg)  right_next  = nr;
                if (nb > bottom_reg) bottom_next = nb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= 1'b0;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else
        begin
            flag_reg   <= flag_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

    assign rpt.valid  = flag_reg;
    assign rpt.left   = flag_reg ? left_reg   : '0;
    assign rpt.top    = flag_reg ? top_reg    : '0;
    assign rpt.right  = flag_reg ? right_reg  : '0;
    assign rpt.bottom = flag_reg ? bottom_reg : '0;

    // a live box always has area
    a_box_area: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> (left_reg < right_reg) && (top_reg < bottom_reg))
        else $error("dirty box without area");

    // present empties the box
    a_present_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.present) |=> !flag_reg)
        else $error("dirty box survived present");

endmodule

// File: rtl/core/clipped_pixel_blend_dirty_rect_top.sv
// pixel writer for a back buffer with alpha blend and dirty box tracking
//
// s_* channel: one word per operation, s_tuser carries the operation
//   (write, blend, mark, present), s_tdata the coordinates, rectangle
//   size, color, alpha and the old destination pixel
// m_* channel: exactly one result word for every accepted word, in order;
//   pixel ops give the write strobe, byte address and bytes to store,
//   present gives the dirty box, every field an op does not use is zero
// cfg port: cfg_we writes register cfg_index with cfg_data; the user writes
//   only while the block is idle, the block itself does not enforce it
//
// pipeline: an accepted word passes two register stages, the input register
//   and then the result register, whose valid flag drives m_tvalid
// throughput: one word per cycle unless m_tready stalls; the whole op (clip,
//   blend multiply and divide by 255, address multiply, box merge) sits
//   between the two registers, and the box update lands in the same cycle
// stall: while m_tready is low the result register holds; the input
//   register still takes one more word, then s_tready drops
// reset: screen 1024x768, line 4096 bytes, 4 bytes per pixel, clip window
//   open, dirty box empty, both stages empty
module clipped_pixel_blend_dirty_rect_top
    import cpbdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // x_pos[15:0], y_pos[31:16], rect_width[47:32], rect_height[63:48],
    // color[87:64], alpha[95:88], old_pixel[119:96]
    input  logic [119:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // write_enable[0], byte_address[26:1], pixel_bytes[50:27],
    // write_fourth_byte[51], dirty_valid[52], dirty_left[65:53],
    // dirty_top[78:66], dirty_right[91:79], dirty_bottom[104:92], zero[111:105]
    output logic [111:0] m_tdata,

    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [14:0]  cfg_data
);

    // result word layout
    typedef struct packed {
        dirty_rpt_t  box;
        logic        fourth;
        logic [23:0] pixel;
        logic [25:0] addr;
        logic        wen;
    } result_t;

    // configuration registers
    logic [12:0] screen_width_reg, screen_height_reg;
    logic [14:0] line_bytes_reg;
    logic [2:0]  bpp_reg;
    logic [12:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= 13'd1024;
            screen_height_reg <= 13'd768;
            line_bytes_reg    <= 15'd4096;
            bpp_reg           <= 3'd4;
            clip_left_reg     <= '0;
            clip_top_reg      <= '0;
            clip_right_reg    <= DIM_NO_CLIP;
            clip_bottom_reg   <= DIM_NO_CLIP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                REG_LINE_BYTES:    line_bytes_reg    <= cfg_data;
                REG_BYTES_PER_PIX: bpp_reg           <= cfg_data[2:0];
                REG_CLIP_LEFT:     clip_left_reg     <= cfg_data[12:0];
                REG_CLIP_TOP:      clip_top_reg      <= cfg_data[12:0];
                REG_CLIP_RIGHT:    clip_right_reg    <= cfg_data[12:0];
                REG_CLIP_BOTTOM:   clip_bottom_reg   <= cfg_data[12:0];
                default:           ;
            endcase
        end
    end

    // handshake: input register feeds the result register
    logic          in_valid_reg, in_valid_next;
    logic [119:0]  in_data_reg;
    logic [1:0]    in_op_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, res;
    logic          advance, fire, take;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
        if (fire)
            out_reg <= res;
    end

    // unpack the held word
    logic signed [15:0] x_pos, y_pos, rect_width, rect_height;
    logic [23:0]        color, old_pixel;
    logic [7:0]         alpha;

    assign x_pos       = $signed(in_data_reg[15:0]);
    assign y_pos       = $signed(in_data_reg[31:16]);
    assign rect_width  = $signed(in_data_reg[47:32]);
    assign rect_height = $signed(in_data_reg[63:48]);
    assign color       = in_data_reg[87:64];
    assign alpha       = in_data_reg[95:88];
    assign old_pixel   = in_data_reg[119:96];

    // pixel path: clip test, screen test, blend, address
    logic               is_pixel, is_blend, is_mark, is_present;
    logic signed [16:0] xs, ys;
    logic               in_clip, on_screen, pix_wen;
    logic [23:0]        mixed, pix_bytes;
    logic [27:0]        y_prod, addr_sum;
    logic [15:0]        x_prod;

    assign is_blend   = (in_op_reg == OP_BLEND);
    assign is_pixel   = (in_op_reg == OP_WRITE) || is_blend;
    assign is_mark    = (in_op_reg == OP_MARK);
    assign is_present = (in_op_reg == OP_PRESENT);

    always_comb
    begin
        xs = 17'(x_pos);
        ys = 17'(y_pos);
        in_clip = (xs >= $signed({4'd0, clip_left_reg}))
               && (xs <  $signed({4'd0, clip_right_reg}))
               && (ys >= $signed({4'd0, clip_top_reg}))
               && (ys <  $signed({4'd0, clip_bottom_reg}));
        on_screen = !x_pos[15] && !y_pos[15]
               && (xs < $signed({4'd0, screen_width_reg}))
               && (ys < $signed({4'd0, screen_height_reg}));
        // transparent blend writes nothing
        pix_wen = is_pixel && in_clip && on_screen && !(is_blend && alpha == '0);
    end

    cpbdr_blend u_blend (
        .color     (color),
        .old_pixel (old_pixel),
        .alpha     (alpha),
        .mixed     (mixed)
    );

    assign pix_bytes = is_blend ? mixed : color;

    // only in-screen points matter, so 13 bits of each coordinate suffice
    assign y_prod   = y_pos[12:0] * line_bytes_reg;
    assign x_prod   = x_pos[12:0] * bpp_reg;
    assign addr_sum = y_prod + {12'd0, x_prod};

    // dirty box
    dirty_req_t dreq;
    dirty_rpt_t drpt;

    always_comb
    begin
        dreq.merge   = pix_wen || is_mark;
        dreq.present = is_present;
        dreq.x       = x_pos;
        dreq.y       = y_pos;
        dreq.w       = is_mark ? rect_width  : 16'sd1;
        dreq.h       = is_mark ? rect_height : 16'sd1;
    end

    cpbdr_dirty u_dirty (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .req           (dreq),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .rpt           (drpt)
    );

    // result word, unused fields zero
    always_comb
    begin
        res        = '0;
        res.wen    = pix_wen;
        res.addr   = pix_wen ? addr_sum[25:0] : '0;
        res.pixel  = pix_wen ? pix_bytes : '0;
        res.fourth = pix_wen && (bpp_reg > 3'd3);
        res.box    = is_present ? drpt : '0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

    // a result is either a pixel write or a box report, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.wen && out_reg.box.valid))
        else $error("pixel write and box report in one word");

    // without a write every pixel field is zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_reg.wen) |-> (out_reg.addr == '0) && (out_reg.pixel == '0)
            && !out_reg.fourth)
        else $error("pixel fields set without a write");

    // an empty input register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // a held word moves on as soon as the result register frees up
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("result lost between stages");

endmodule

// File: sim/testbench.sv
import cpbdr_pkg::*;

// one input word, lowest field in the lowest bits
typedef struct packed {
    logic [23:0]        old_pixel;
    logic [7:0]         alpha;
    logic [23:0]        color;
    logic signed [15:0] rect_height;
    logic signed [15:0] rect_width;
    logic signed [15:0] y_pos;
    logic signed [15:0] x_pos;
} pix_word_t;

// one result word, lowest field in the lowest bits
typedef struct packed {
    logic [6:0]  zero_pad;
    logic [12:0] dirty_bottom;
    logic [12:0] dirty_right;
    logic [12:0] dirty_top;
    logic [12:0] dirty_left;
    logic        dirty_valid;
    logic        write_fourth_byte;
    logic [23:0] pixel_bytes;
    logic [25:0] byte_address;
    logic        write_enable;
} result_word_t;

class pixel_scoreboard;
    logic [12:0]  scr_w, scr_h, clip_l, clip_t, clip_r, clip_b;
    logic [14:0]  line_b;
    logic [2:0]   bpp;
    bit           box_live;
    longint       box_l, box_t, box_r, box_b;
    result_word_t queued_results[$];
    int           errors;

    function new();
        scr_w    = 13'd1024;
        scr_h    = 13'd768;
        line_b   = 15'd4096;
        bpp      = 3'd4;
        clip_l   = '0;
        clip_t   = '0;
        clip_r   = DIM_NO_CLIP;
        clip_b   = DIM_NO_CLIP;
        box_live = 1'b0;
        box_l    = 0;
        box_t    = 0;
        box_r    = 0;
        box_b    = 0;
        errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [14:0] v);
        case (idx)
            REG_SCREEN_WIDTH:  scr_w  = v[12:0];
            REG_SCREEN_HEIGHT: scr_h  = v[12:0];
            REG_LINE_BYTES:    line_b = v;
            REG_BYTES_PER_PIX: bpp    = v[2:0];
            REG_CLIP_LEFT:     clip_l = v[12:0];
            REG_CLIP_TOP:      clip_t = v[12:0];
            REG_CLIP_RIGHT:    clip_r = v[12:0];
            REG_CLIP_BOTTOM:   clip_b = v[12:0];
            default:
            begin
            end
        endcase
    endfunction

    // clamp to the screen, then grow the dirty box
    function void merge_box(longint x, longint y, longint w, longint h);
        longint sw, sh;
        sw = scr_w;
        sh = scr_h;
        if (x < 0)
        begin
            w += x;
            x = 0;
        end
        if (y < 0)
        begin
            h += y;
            y = 0;
        end
        if (x + w > sw)
            w = sw - x;
        if (y + h > sh)
            h = sh - y;
        if (w <= 0 || h <= 0)
            return;
        if (!box_live)
        begin
            box_l    = x;
            box_t    = y;
            box_r    = x + w;
            box_b    = y + h;
            box_live = 1'b1;
        end
        else
        begin
            if (x < box_l)
                box_l = x;
            if (y < box_t)
                box_t = y;
            if (x + w > box_r)
                box_r = x + w;
            if (y + h > box_b)
                box_b = y + h;
        end
    endfunction

    function int blend_channel(int c, int o, int a);
        return (c * a + o * (255 - a)) / 255;
    endfunction

    function result_word_t render_op(logic [1:0] op, pix_word_t w);
        result_word_t r;
        longint       x, y, cl, ct, cr, cb, sw, sh;
        int           a;
        r  = '0;
        x  = longint'(w.x_pos);
        y  = longint'(w.y_pos);
        cl = clip_l;
        ct = clip_t;
        cr = clip_r;
        cb = clip_b;
        sw = scr_w;
        sh = scr_h;
        a  = w.alpha;
        if (op == OP_WRITE || op == OP_BLEND)
        begin
            if (x < cl || x >= cr || y < ct || y >= cb)
                return r;
            if (x < 0 || y < 0 || x >= sw || y >= sh)
                return r;
            if (op == OP_BLEND && a == 0)
                return r;
            if (op == OP_WRITE || a == ALPHA_OPAQUE)
                r.pixel_bytes = w.color;
            else
                for (int k = 0; k < 3; k++)
                    r.pixel_bytes[8*k +: 8] = 8'(blend_channel(w.color[8*k +: 8],
                                                 w.old_pixel[8*k +: 8], a));
            r.write_enable      = 1'b1;
            r.byte_address      = 26'(y * longint'(line_b) + x * longint'(bpp));
            r.write_fourth_byte = (bpp > 3'd3);
            merge_box(x, y, 1, 1);
        end
        else if (op == OP_MARK)
            merge_box(x, y, longint'(w.rect_width), longint'(w.rect_height));
        else
        begin
            if (box_live)
            begin
                r.dirty_valid  = 1'b1;
                r.dirty_left   = 13'(box_l);
                r.dirty_top    = 13'(box_t);
                r.dirty_right  = 13'(box_r);
                r.dirty_bottom = 13'(box_b);
            end
            box_live = 1'b0;
        end
        return r;
    endfunction

    function void note_word(logic [1:0] op, pix_word_t w);
        queued_results.push_back(render_op(op, w));
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(result_word_t got);
        result_word_t want;
        if (queued_results.size() == 0)
        begin
            $error("result word with nothing pending: %h", got);
            errors++;
            return;
        end
        want = queued_results.pop_front();
        cmp("write_enable", want.write_enable, got.write_enable);
        cmp("byte_address", want.byte_address, got.byte_address);
        cmp("pixel_bytes", want.pixel_bytes, got.pixel_bytes);
        cmp("write_fourth_byte", want.write_fourth_byte, got.write_fourth_byte);
        cmp("dirty_valid", want.dirty_valid, got.dirty_valid);
        cmp("dirty_left", want.dirty_left, got.dirty_left);
        cmp("dirty_top", want.dirty_top, got.dirty_top);
        cmp("dirty_right", want.dirty_right, got.dirty_right);
        cmp("dirty_bottom", want.dirty_bottom, got.dirty_bottom);
        cmp("zero_pad", want.zero_pad, got.zero_pad);
    endfunction

    function int outstanding();
        return queued_results.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // register values for one phase of the run
    typedef struct {
        int w, h, line, bpp, cl, ct, cr, cb;
    } setup_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;   // x_pos, y_pos, rect_width, rect_height, color, alpha, old_pixel
    logic [1:0]   s_tuser   = '0;   // op
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [111:0] m_tdata;          // write_enable, byte_address, pixel_bytes, write_fourth_byte,
                                    // dirty_valid, dirty_left, dirty_top, dirty_right, dirty_bottom
    logic         cfg_we    = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [14:0]  cfg_data  = '0;

    pixel_scoreboard sb;

    // idle percentages of the two sides, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // long receiver hold-off, requested by the stimulus, counted by the receiver
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    clipped_pixel_blend_dirty_rect_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // inputs only change at the rising edge, so the falling edge sees what the
    // next rising edge will accept
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // offer one word, idling first at random, and hold it until taken
    task automatic send_word(input logic [1:0] op, input pix_word_t w);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= w;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            if (taken)
                sb.note_word(op, w);
            @(posedge clk);
        end
    endtask

    task automatic send_fields(input logic [1:0] op, input int x, input int y,
                               input int rw, input int rh, input logic [23:0] color,
                               input int alpha, input logic [23:0] old);
        pix_word_t w;
        w.x_pos       = 16'(x);
        w.y_pos       = 16'(y);
        w.rect_width  = 16'(rw);
        w.rect_height = 16'(rh);
        w.color       = color;
        w.alpha       = 8'(alpha);
        w.old_pixel   = old;
        send_word(op, w);
    endtask

    // stop offering and wait until every result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // write all eight registers, block idle
    task automatic program_regs(input setup_t s);
        logic [2:0]  idx  [8];
        logic [14:0] val  [8];
        logic [14:0] keep [8];
        logic [14:0] junk;
        idx  = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_LINE_BYTES, REG_BYTES_PER_PIX,
                 REG_CLIP_LEFT, REG_CLIP_TOP, REG_CLIP_RIGHT, REG_CLIP_BOTTOM};
        val  = '{15'(s.w), 15'(s.h), 15'(s.line), 15'(s.bpp),
                 15'(s.cl), 15'(s.ct), 15'(s.cr), 15'(s.cb)};
        keep = '{15'h1FFF, 15'h1FFF, 15'h7FFF, 15'h0007,
                 15'h1FFF, 15'h1FFF, 15'h1FFF, 15'h1FFF};
        for (int i = 0; i < 8; i++)
        begin
            // stray bits above the register width now and then, to be dropped
            junk = ($urandom_range(3) == 0) ? (15'($urandom) & ~keep[i]) : '0;
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i] | junk;
            @(posedge clk);
            sb.set_reg(idx[i], val[i] | junk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic setup_t random_setup();
        setup_t s;
        s.w    = $urandom_range(1, MAX_DIM);
        s.h    = $urandom_range(1, MAX_DIM);
        s.line = $urandom_range(1, 16384);
        s.bpp  = ($urandom_range(2) == 0) ? $urandom_range(7) : $urandom_range(3, 4);
        s.cl   = $urandom_range(0, s.w);
        s.ct   = $urandom_range(0, s.h);
        s.cr   = ($urandom_range(3) == 0) ? MAX_DIM : $urandom_range(s.cl, MAX_DIM);
        s.cb   = ($urandom_range(3) == 0) ? MAX_DIM : $urandom_range(s.ct, MAX_DIM);
        return s;
    endfunction

    // mostly near the screen, sometimes on a clip edge, sometimes anywhere
    function automatic logic [15:0] pick_coord(int span, int lo_edge, int hi_edge);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'($urandom);
        if (sel == 1)
            return 16'(lo_edge - 1 + int'($urandom_range(1)));
        if (sel == 2)
            return 16'(hi_edge - 1 + int'($urandom_range(1)));
        return 16'(int'($urandom_range(span + 7)) - 4);
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return OP_WRITE;
        if (r < 70)
            return OP_BLEND;
        if (r < 88)
            return OP_MARK;
        return OP_PRESENT;
    endfunction

    function automatic pix_word_t random_word(logic [1:0] op);
        pix_word_t w;
        int        r;
        w.x_pos       = pick_coord(sb.scr_w, sb.clip_l, sb.clip_r);
        w.y_pos       = pick_coord(sb.scr_h, sb.clip_t, sb.clip_b);
        w.rect_width  = 16'($urandom);
        w.rect_height = 16'($urandom);
        w.color       = 24'($urandom);
        w.alpha       = 8'($urandom);
        w.old_pixel   = 24'($urandom);
        r = $urandom_range(9);
        // transparent and opaque blends show up often
        if (op == OP_BLEND && r == 0)
            w.alpha = '0;
        else if (op == OP_BLEND && r == 1)
            w.alpha = ALPHA_OPAQUE;
        // marks: mostly small boxes, some as big as the screen, some anything
        if (op == OP_MARK && r >= 2)
        begin
            if (r < 4)
            begin
                w.rect_width  = 16'(int'(sb.scr_w) + int'($urandom_range(8)) - 4);
                w.rect_height = 16'(int'(sb.scr_h) + int'($urandom_range(8)) - 4);
            end
            else
            begin
                w.rect_width  = 16'(int'($urandom_range(48)) - 4);
                w.rect_height = 16'(int'($urandom_range(48)) - 4);
            end
        end
        return w;
    endfunction

    initial
    begin
        setup_t     s;
        int         count;
        logic [1:0] op;

        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on the reset setup: 1024x768, 4096-byte lines, 4 bytes per pixel
        send_idle_pct = 31;
        recv_idle_pct = 65;
        send_fields(OP_PRESENT, 0, 0, 0, 0, 24'h0, 0, 24'h0);             // nothing dirty yet
        send_fields(OP_WRITE, 0, 0, 0, 0, 24'hFFFFFF, 0, 24'h0);
        send_fields(OP_WRITE, 1023, 767, 0, 0, 24'h000000, 255, 24'hFFFFFF);
        send_fields(OP_WRITE, 1024, 0, 0, 0, 24'h123456, 0, 24'h0);        // just off the right
        send_fields(OP_WRITE, -1, 5, 0, 0, 24'h123456, 0, 24'h0);
        send_fields(OP_WRITE, 0, -32768, 0, 0, 24'h123456, 0, 24'h0);
        send_fields(OP_WRITE, 32767, 32767, 0, 0, 24'h123456, 0, 24'h0);
        send_fields(OP_BLEND, 10, 10, 0, 0, 24'hABCDEF, 0, 24'h111111);    // transparent
        send_fields(OP_BLEND, 20, 20, 0, 0, 24'hABCDEF, 255, 24'h111111);  // opaque
        send_fields(OP_BLEND, 30, 30, 0, 0, 24'hFF00FF, 128, 24'h00FF00);
        send_fields(OP_BLEND, 31, 30, 0, 0, 24'hFFFFFF, 1, 24'h000000);
        send_fields(OP_BLEND, 32, 30, 0, 0, 24'h000000, 254, 24'hFFFFFF);
        send_fields(OP_PRESENT, 0, 0, 0, 0, 24'h0, 0, 24'h0);
        send_fields(OP_MARK, -10, -10, 20, 20, 24'h0, 0, 24'h0);           // clamped at the origin
        send_fields(OP_MARK, 100, 100, 0, 5, 24'h0, 0, 24'h0);             // no width
        send_fields(OP_MARK, 5, 5, -3, 4, 24'h0, 0, 24'h0);                // negative width
        send_fields(OP_MARK, 2000, 10, 5, 5, 24'h0, 0, 24'h0);             // off screen
        send_fields(OP_MARK, -32768, -32768, 32767, 32767, 24'h0, 0, 24'h0);
        send_fields(OP_MARK, 1000, 700, 32767, 32767, 24'h0, 0, 24'h0);    // past the corner
        send_fields(OP_PRESENT, 0, 0, 0, 0, 24'h0, 0, 24'h0);
        send_fields(OP_PRESENT, 0, 0, 0, 0, 24'h0, 0, 24'h0);              // box just cleared
        send_fields(OP_MARK, 32767, -1, -32768, 2, 24'h0, 0, 24'h0);
        send_fields(OP_PRESENT, 0, 0, 0, 0, 24'h0, 0, 24'h0);
        drain();

        // random phases, each with its own register setup
        for (int p = 0; p < 9; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            count = 200;
            case (p)
                0:
                begin
                    // largest screen, odd pixel size, addresses wrap
                    s     = '{4096, 4096, 16384, 7, 0, 0, 4096, 4096};
                    count = 150;
                end
                1:
                begin
                    // one-pixel screen
                    s     = '{1, 1, 1, 3, 0, 0, 4096, 4096};
                    count = 60;
                end
                2:
                    s = '{320, 200, 960, 3, 16, 8, 300, 190};
                3:
                begin
                    // one-pixel clip window
                    s     = '{640, 480, 2560, 4, 100, 50, 101, 51};
                    count = 80;
                end
                4:
                begin
                    // clip window shut, zero pixel size
                    s     = '{800, 600, 3200, 0, 4096, 4096, 0, 0};
                    count = 40;
                end
                7:
                    s = '{1024, 768, 4096, 4, 0, 0, 4096, 4096};
                8:
                begin
                    s     = '{4096, 1, 16384, 4, 0, 0, 4096, 4096};
                    count = 170;
                end
                default:
                    s = random_setup();
            endcase
            program_regs(s);
            for (int i = 0; i < count; i++)
            begin
                // receiver holds off while words keep coming, later a full pause
                if (p == 7 && i == 20)
                    hold_req = 1'b1;
                if (p == 7 && i == 120)
                    drain();
                op = pick_op();
                send_word(op, random_word(op));
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
